// File: design/dkrs_pkg.sv
// ----------------------------------------------------------------------------
// dkrs_pkg
// Shared types and constants for the date-keyed record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dkrs_pkg;

  localparam int unsigned YEAR_W        = 12;
  localparam int unsigned MONTH_W       = 4;
  localparam int unsigned DAY_W         = 5;
  localparam int unsigned HANDLE_W      = 16;
  localparam int unsigned KEY_W         = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned DEFAULT_DEPTH = 64;

  // Payload carried by every cell: packed date key and handle.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } rec_t;

  // Chain-wide command broadcast to all cells.
  typedef struct packed {
    logic insert;  // place the broadcast record, shift the tail up
    logic drain;   // shift every cell one place toward the head
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

`default_nettype wire

// File: design/dkrs_cell.sv
// ----------------------------------------------------------------------------
// dkrs_cell
// One slot of the insertion chain: holds one record and its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dkrs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dkrs_pkg::ctrl_t ctrl_i,
  input  dkrs_pkg::rec_t  new_i,        // broadcast record
  input  dkrs_pkg::rec_t  prev_i,       // neighbor toward the head
  input  logic           prev_valid_i,
  input  logic           prev_take_i,  // neighbor toward the head takes too
  input  dkrs_pkg::rec_t  next_i,       // neighbor toward the tail
  input  logic           next_valid_i,
  output dkrs_pkg::rec_t  rec_o,
  output logic           valid_o,
  output logic           take_o
);
  import dkrs_pkg::*;

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;

  // Slot is at or past the insertion point: empty, or strictly later key.
  // Equal keys stay ahead, so equal dates keep arrival order.
  assign take_o = !valid_q || (rec_q.key > new_i.key);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.drain) begin
      rec_d   = next_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert && take_o) begin
      if (prev_take_i) begin
        rec_d   = prev_i;
        valid_d = prev_valid_i;
      end else begin
        rec_d   = new_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: design/date_key_record_sorter.sv
// ----------------------------------------------------------------------------
// date_key_record_sorter
// Batch sorter for dated records built as a systolic insertion chain.
// ----------------------------------------------------------------------------
// Records enter one item per cycle while in_stall_o is low; each is placed in
// its sorted slot in the same cycle: every cell of the DEPTH-long chain
// compares its own key with the broadcast key, and all cells past the
// insertion point shift one place toward the tail. Order is ascending by
// (year, month, day); equal dates keep their arrival order. Once the chain is
// full, further records are dropped and the batch reports overflowed_o on
// every result. The item carrying batch_end is placed first, then the chain
// drains from its head, one result per cycle while out_stall_i is low, the
// final result marked by out_last_o. Input is stalled during the drain, and
// results leave only through the single output port at the chain head. The
// store needs no clearing pass: each cell has its own valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module date_key_record_sorter #(
  parameter int unsigned DEPTH = dkrs_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dkrs_pkg::YEAR_W-1:0]   rec_year_i,
  input  logic [dkrs_pkg::MONTH_W-1:0]  rec_month_i,
  input  logic [dkrs_pkg::DAY_W-1:0]    rec_day_i,
  input  logic [dkrs_pkg::HANDLE_W-1:0] rec_handle_i,
  input  logic                          batch_end_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dkrs_pkg::YEAR_W-1:0]   out_year_o,
  output logic [dkrs_pkg::MONTH_W-1:0]  out_month_o,
  output logic [dkrs_pkg::DAY_W-1:0]    out_day_o,
  output logic [dkrs_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                          out_last_o,
  output logic                          overflowed_o
);
  import dkrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;

  logic out_valid_q, out_valid_d;
  rec_t out_rec_q, out_rec_d;
  logic out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  logic in_accept, full, emit;
  ctrl_t ctrl;
  rec_t new_rec;

  rec_t cell_rec   [DEPTH];
  logic cell_valid [DEPTH];
  logic cell_take  [DEPTH];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNT_W'(DEPTH));
  // Output slot is free, or being emptied this cycle.
  assign emit       = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);

  assign new_rec.key    = {rec_year_i, rec_month_i, rec_day_i};
  assign new_rec.handle = rec_handle_i;

  assign ctrl.insert = in_accept && !full;
  assign ctrl.drain  = emit;

  // ---- chain of cells -----------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_valid, prev_take, next_valid;

    if (i == 0) begin : g_head
      assign prev_rec   = '0;
      assign prev_valid = 1'b0;
      assign prev_take  = 1'b0;
    end else begin : g_body
      assign prev_rec   = cell_rec[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_take  = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_rec   = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_rec   = cell_rec[i+1];
      assign next_valid = cell_valid[i+1];
    end

    dkrs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (new_rec),
      .prev_i       (prev_rec),
      .prev_valid_i (prev_valid),
      .prev_take_i  (prev_take),
      .next_i       (next_rec),
      .next_valid_i (next_valid),
      .rec_o        (cell_rec[i]),
      .valid_o      (cell_valid[i]),
      .take_o       (cell_take[i])
    );
  end

  // ---- control ------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rec_d   = out_rec_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (full) begin
            ovf_d = 1'b1;            // record dropped
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (batch_end_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_rec_d   = cell_rec[0];
          out_last_d  = (cnt_q == CNT_W'(1));
          out_ovf_d   = ovf_q;
          cnt_d       = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q  <= out_rec_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_year_o   = out_rec_q.key[KEY_W-1 -: YEAR_W];
  assign out_month_o  = out_rec_q.key[DAY_W +: MONTH_W];
  assign out_day_o    = out_rec_q.key[DAY_W-1:0];
  assign out_handle_o = out_rec_q.handle;
  assign out_last_o   = out_last_q;
  assign overflowed_o = out_ovf_q;

  // ---- assertions ---------------------------------------------------------
  // Head cell holds a record exactly when the count is nonzero.
  a_head_matches_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (cnt_q != '0))
    else $error("head cell valid disagrees with record count");

  // A drain never runs on an empty chain.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (cnt_q != '0))
    else $error("drain with empty chain");

  // Emitting the final record ends the batch and clears the overflow mark.
  a_last_ends_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cnt_q == CNT_W'(1)) |=> (state_q == ST_IDLE && !ovf_q && out_last_q))
    else $error("final record did not close the batch");

  // Count never exceeds the chain length.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("record count beyond depth");

endmodule

`default_nettype wire
